// ===== hw/rtl/message_id_counter_table_defines.svh =====
// assertion macros for the message id counter table
// used by the top level; no other dependencies
`ifndef MESSAGE_ID_COUNTER_TABLE_DEFINES_SVH
`define MESSAGE_ID_COUNTER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MICT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mict assertion failed");
// condition must never be true outside reset
`define MICT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mict forbidden condition seen");
`else
`define MICT_ASSERT(label, clk, rst_n, prop)
`define MICT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/mict_pkg.sv =====
// shared types and constants of the message id counter table
// no dependencies
`default_nettype none

package mict_pkg;

	localparam int ENTRIES_DEFAULT = 255;
	localparam int ID_W            = 24;
	localparam int CMD_W           = 16;
	localparam int COUNT_W         = 32;
	localparam int SLOT_W          = 8;
	localparam int STATUS_W        = 2;

	// id whose entries also compare the command code
	localparam logic [ID_W-1:0] CMD_LONG_ID = ID_W'(76);

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_MATCH   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ADDED   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_CLEARED = 2'd3;

	// request type codes
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// one table entry as stored in memory
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [CMD_W-1:0]   cmd;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// outcome of comparing one entry against the item
	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] count_next;
	} match_t;

endpackage

`default_nettype wire

// ===== hw/rtl/message_id_counter_table.sv =====
// top level of the message id counter table: sequencer, fill level, result regs
// depends on mict_pkg, mict_mem, mict_match and the defines header
//
// channel  | signals                              | handshake
// request  | req_type, msg_id, command_code       | taken when start && !busy
// result   | status, slot, hit_count              | one-cycle strobe on done
//
// for a clear item, done follows on the next cycle
// a record item scans slots 0 upward, one memory read per cycle: it ends at the
// first slot that hits, or with a miss once all fill_level slots have been read
// the single memory read port sets this pace
// busy stays high until any write-back has landed, so the next item reads fresh data
// reset empties the table at once; no clearing pass. the receiver cannot stall
`default_nettype none
`include "message_id_counter_table_defines.svh"

module message_id_counter_table import mict_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                req_type,
	input  wire logic [ID_W-1:0]     msg_id,
	input  wire logic [CMD_W-1:0]    command_code,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [SLOT_W-1:0]        slot,
	output logic [COUNT_W-1:0]       hit_count
);

	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic              state_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] addr_q;
	logic              pend_q;
	logic [FILL_W-1:0] idx_s1;
	logic [ID_W-1:0]   id_q;
	logic [CMD_W-1:0]  cmd_q;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  hit_count_q;

	logic              accept;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;
	entry_t            rd_entry;
	match_t            match;
	logic              scan_hit;
	logic              scan_miss;
	logic              has_room;
	logic [FILL_W+SLOT_W-1:0] hit_slot_wide;
	logic [FILL_W+SLOT_W-1:0] add_slot_wide;

	assign busy   = (state_q == ST_SCAN);
	assign accept = start && !busy;

	// scan control: issue reads while slots remain, check the one in flight
	assign rd_en     = (state_q == ST_SCAN) && (addr_q < fill_q);
	assign scan_hit  = (state_q == ST_SCAN) && pend_q && match.hit;
	assign scan_miss = (state_q == ST_SCAN) && !pend_q && (addr_q >= fill_q);
	assign has_room  = (fill_q < FILL_W'(ENTRIES));

	assign hit_slot_wide = {{SLOT_W{1'b0}}, idx_s1};
	assign add_slot_wide = {{SLOT_W{1'b0}}, fill_q};

	// write-back: counter update on hit, new entry on miss with room
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1[ADDR_W-1:0];
		wr_data = '{id: rd_entry.id, cmd: rd_entry.cmd, count: match.count_next};
		if (scan_hit) begin
			wr_en = 1'b1;
		end else if (scan_miss && has_room) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[ADDR_W-1:0];
			wr_data = '{id: id_q, cmd: cmd_q, count: '0};
		end
	end

	mict_mem #(
		.ENTRIES (ENTRIES),
		.ADDR_W  (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_q[ADDR_W-1:0]),
		.rd_data (rd_entry)
	);

	mict_match u_match (
		.entry        (rd_entry),
		.msg_id       (id_q),
		.command_code (cmd_q),
		.result       (match)
	);

	// sequencer and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			addr_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == REQ_CLEAR) begin
							fill_q <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
							addr_q  <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					pend_q <= rd_en;
					if (rd_en) begin
						addr_q <= addr_q + FILL_W'(1);
					end
					if (scan_hit || scan_miss) begin
						state_q <= ST_IDLE;
						pend_q  <= 1'b0;
						done_q  <= 1'b1;
					end
					if (scan_miss && has_room) begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and read pipeline index
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= msg_id;
			cmd_q <= command_code;
		end
		if (rd_en) begin
			idx_s1 <= addr_q;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_CLEAR) begin
			status_q    <= STAT_CLEARED;
			slot_q      <= '0;
			hit_count_q <= '0;
		end else if (scan_hit) begin
			status_q    <= STAT_MATCH;
			slot_q      <= hit_slot_wide[SLOT_W-1:0];
			hit_count_q <= match.count_next;
		end else if (scan_miss && has_room) begin
			status_q    <= STAT_ADDED;
			slot_q      <= add_slot_wide[SLOT_W-1:0];
			hit_count_q <= '0;
		end else if (scan_miss) begin
			status_q    <= STAT_FULL;
			slot_q      <= '0;
			hit_count_q <= '0;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign hit_count = hit_count_q;

	// checks
	`MICT_ASSERT(a_clear_done, clk, arst_n, (accept && req_type == REQ_CLEAR) |=> (done && status == STAT_CLEARED))
	`MICT_NEVER(a_fill_bound, clk, arst_n, fill_q > FILL_W'(ENTRIES))
	`MICT_ASSERT(a_write_ends_item, clk, arst_n, wr_en |=> (done && state_q == ST_IDLE))
	`MICT_ASSERT(a_full_at_limit, clk, arst_n, (done && status == STAT_FULL) |-> (fill_q == FILL_W'(ENTRIES)))

endmodule

`default_nettype wire

// ===== hw/rtl/mict_mem.sv =====
// entry memory: one write port, one read port, registered read data
// depends on mict_pkg
`default_nettype none

module mict_mem import mict_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	parameter int ADDR_W  = 8
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire entry_t            wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output entry_t                 rd_data
);

	entry_t mem [ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mict_match.sv =====
// compare rule for one entry and saturating counter update
// depends on mict_pkg
`default_nettype none

module mict_match import mict_pkg::*; (
	input  wire entry_t            entry,
	input  wire logic [ID_W-1:0]   msg_id,
	input  wire logic [CMD_W-1:0]  command_code,
	output match_t                 result
);

	always_comb begin
		// command-long entries need both id and command code to agree
		if (entry.id == CMD_LONG_ID) begin
			result.hit = (msg_id == CMD_LONG_ID) && (entry.cmd == command_code);
		end else begin
			result.hit = (entry.id == msg_id);
		end
		// counter sticks at all ones
		if (&entry.count) begin
			result.count_next = entry.count;
		end else begin
			result.count_next = entry.count + COUNT_W'(1);
		end
	end

endmodule

`default_nettype wire
